### sv/cdcf_pkg.sv
package cdcf_pkg;

  // sequencer states of the top level
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MAC,
    S_DIV,
    S_PUSH
  } state_t;

  // handshake between the sequencer and a multi-cycle unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_KERN_TOP    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_KERN_MIDDLE = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_KERN_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIVISOR     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH       = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT      = 3'd5;

  // register and field widths
  localparam int KERN_BITS    = 48;
  localparam int FIELD_BITS   = 16;
  localparam int DIV_BITS     = 16;
  localparam int WID_REG_BITS = 11;
  localparam int HGT_BITS     = 13;
  localparam int ROW_BITS     = 12;
  localparam int COL_OUT_BITS = 10;
  localparam int OUT_BITS     = 8;

  // geometry limits
  localparam int MIN_DIM    = 3;
  localparam int MAX_HEIGHT = 4096;

  // taps of the 3x3 window
  localparam int MAC_TAPS = 9;

  // output clamp ceiling
  localparam logic [OUT_BITS-1:0] OUT_MAX = 8'd255;

  // register reset values (identity kernel, no division)
  localparam logic [KERN_BITS-1:0]    KERN_MID_RST = 48'h0000_0001_0000;
  localparam logic [DIV_BITS-1:0]     DIV_RST      = 16'd1;
  localparam logic [WID_REG_BITS-1:0] WIDTH_RST    = 11'd1024;
  localparam logic [HGT_BITS-1:0]     HEIGHT_RST   = 13'd768;

endpackage

### sv/cdcf_line_mem.sv
module cdcf_line_mem #(
  parameter int DEPTH = 1024,
  parameter int DW    = 16
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data
);

  logic [DW-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/cdcf_mac.sv
module cdcf_mac #(
  parameter int PIXEL_BITS = 8,
  parameter int COEF_BITS  = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         start,
  input  logic [2:0][cdcf_pkg::KERN_BITS-1:0]          kern,
  input  logic [2:0][2:0][PIXEL_BITS-1:0]              win,
  output cdcf_pkg::unit_status_t                       status,
  output logic signed [PIXEL_BITS+COEF_BITS+3:0]       sum
);

  localparam int SW  = PIXEL_BITS + COEF_BITS + 4;
  localparam int PW  = PIXEL_BITS + COEF_BITS + 1;
  localparam int EXT = SW - PW;

  logic [3:0]                          step;
  logic [1:0]                          kr;
  logic [1:0]                          kc;
  logic                                busy;
  logic                                done;
  logic [cdcf_pkg::KERN_BITS-1:0]      row_sel;
  logic [cdcf_pkg::FIELD_BITS-1:0]     field_sel;
  logic [PIXEL_BITS-1:0]               pix_sel;
  logic signed [COEF_BITS-1:0]         coef_sel;
  logic signed [PW-1:0]                prod;

  assign status = '{busy: busy, done: done};

  // pick the kernel row and the pixel of the current tap
  always_comb begin
    case (kr)
      2'd1:    row_sel = kern[1];
      2'd2:    row_sel = kern[2];
      default: row_sel = kern[0];
    endcase
    case (kc)
      2'd1:    field_sel = row_sel[2*cdcf_pkg::FIELD_BITS-1:cdcf_pkg::FIELD_BITS];
      2'd2:    field_sel = row_sel[3*cdcf_pkg::FIELD_BITS-1:2*cdcf_pkg::FIELD_BITS];
      default: field_sel = row_sel[cdcf_pkg::FIELD_BITS-1:0];
    endcase
    coef_sel = field_sel[COEF_BITS-1:0];
    case ({kr, kc})
      4'b00_01: pix_sel = win[0][1];
      4'b00_10: pix_sel = win[0][2];
      4'b01_00: pix_sel = win[1][0];
      4'b01_01: pix_sel = win[1][1];
      4'b01_10: pix_sel = win[1][2];
      4'b10_00: pix_sel = win[2][0];
      4'b10_01: pix_sel = win[2][1];
      4'b10_10: pix_sel = win[2][2];
      default:  pix_sel = win[0][0];
    endcase
  end

  // control: nine multiply steps, then one last accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
      kr   <= '0;
      kc   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        kr   <= '0;
        kc   <= '0;
      end else if (busy) begin
        step <= step + 4'd1;
        if (kc == 2'd2) begin
          kc <= '0;
          kr <= kr + 2'd1;
        end else begin
          kc <= kc + 2'd1;
        end
        if (step == 4'(cdcf_pkg::MAC_TAPS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // product register, then accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      sum <= '0;
    end else if (busy) begin
      if (step < 4'(cdcf_pkg::MAC_TAPS)) begin
        prod <= $signed({1'b0, pix_sel}) * coef_sel;
      end
      if (step != 4'd0) begin
        sum <= sum + {{EXT{prod[PW-1]}}, prod};
      end
    end
  end

endmodule

### sv/cdcf_div.sv
module cdcf_div #(
  parameter int NW = 27
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [NW-1:0]                     dividend,
  input  logic [cdcf_pkg::DIV_BITS-1:0]     divisor,
  output cdcf_pkg::unit_status_t            status,
  output logic [NW-1:0]                     quotient
);

  localparam int DW = cdcf_pkg::DIV_BITS;
  localparam int CB = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [CB-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  assign status = '{busy: busy, done: done};

  // one restoring step: bring down the next dividend bit
  always_comb begin
    shifted = {rem, quotient[NW-1]};
    diff    = shifted - {1'b0, dsr};
    ge      = shifted >= {1'b0, dsr};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CB'(NW);
      end else if (busy) begin
        cnt <= cnt - CB'(1);
        if (cnt == CB'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      rem      <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      quotient <= {quotient[NW-2:0], ge};
    end
  end

endmodule

### sv/conv3x3_divide_clamp_filter.sv
// 3x3 convolution filter with divide and clamp, one colour plane at a time.
// in channel: one pixel per item in raster order (in_valid, in_stall, pixel).
// out channel: one item per interior pixel with filtered_pixel, out_row,
// out_col and last_of_plane; border pixels give no item.
// cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
// write only while no item is in flight.
// flow: the two line stores share one 1024 x 16 memory, read in the cycle an
// item is taken and written back in the next, so a border item passes through
// S_READ only. An interior item runs through one shared multiplier, nine taps
// plus a drain, then, when divisor > 1 and the sum is not negative, through a
// bit-per-cycle divider; the next item is taken only once its result is loaded
// into the output register.
// reset: registers return to the identity kernel, divisor 1, 1024 x 768,
// position counters and window clear; line store contents stay undefined.
// stall: a result waits in the output register while out_stall is high; items
// are still taken until the next result is ready, then in_stall holds.
module conv3x3_divide_clamp_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int COEF_BITS  = 16,
  parameter int PIXEL_BITS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // pixel in
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [PIXEL_BITS-1:0]                   pixel,
  // result out
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [cdcf_pkg::OUT_BITS-1:0]           filtered_pixel,
  output logic [cdcf_pkg::ROW_BITS-1:0]           out_row,
  output logic [cdcf_pkg::COL_OUT_BITS-1:0]       out_col,
  output logic                                    last_of_plane,
  // configuration
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [cdcf_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [cdcf_pkg::KERN_BITS-1:0]          cfg_data
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int WW  = (CW > cdcf_pkg::WID_REG_BITS) ? CW : cdcf_pkg::WID_REG_BITS;
  localparam int RB  = cdcf_pkg::ROW_BITS;
  localparam int HB  = cdcf_pkg::HGT_BITS;
  localparam int SW  = PIXEL_BITS + COEF_BITS + 4;
  localparam int DVW = SW - 1;
  localparam int OB  = cdcf_pkg::OUT_BITS;

  cdcf_pkg::state_t state;
  cdcf_pkg::state_t state_next;

  logic [2:0][cdcf_pkg::KERN_BITS-1:0]     kern;
  logic [cdcf_pkg::DIV_BITS-1:0]           divisor;
  logic [cdcf_pkg::WID_REG_BITS-1:0]       image_width;
  logic [HB-1:0]                           image_height;

  logic [PIXEL_BITS-1:0]                   px;
  logic [CW-1:0]                           col_cnt;
  logic [RB-1:0]                           row_cnt;
  logic [2:0][2:0][PIXEL_BITS-1:0]         win;
  logic [2*PIXEL_BITS-1:0]                 mem_q;

  logic [CW-1:0]                           w_eff;
  logic [HB-1:0]                           h_eff;
  logic [WW-1:0]                           iw_ext;
  logic [CW-1:0]                           col_inc;
  logic [HB-1:0]                           row_inc;
  logic                                    interior;

  logic [RB-1:0]                           pos_row;
  logic [cdcf_pkg::COL_OUT_BITS-1:0]       pos_col;
  logic                                    pos_last;
  logic [OB-1:0]                           res;

  logic                                    mem_rd;
  logic                                    mem_wr;
  logic                                    mac_start;
  logic                                    div_start;
  logic                                    out_load;
  logic                                    slot_free;

  cdcf_pkg::unit_status_t                  mac_st;
  cdcf_pkg::unit_status_t                  div_st;
  logic signed [SW-1:0]                    mac_sum;
  logic [DVW-1:0]                          quot;
  logic                                    sum_neg;
  logic                                    div_use;
  logic [OB-1:0]                           sum_sat;
  logic [OB-1:0]                           quo_sat;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kern[0]      <= '0;
      kern[1]      <= cdcf_pkg::KERN_MID_RST;
      kern[2]      <= '0;
      divisor      <= cdcf_pkg::DIV_RST;
      image_width  <= cdcf_pkg::WIDTH_RST;
      image_height <= cdcf_pkg::HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cdcf_pkg::REG_KERN_TOP:    kern[0]      <= cfg_data;
        cdcf_pkg::REG_KERN_MIDDLE: kern[1]      <= cfg_data;
        cdcf_pkg::REG_KERN_BOTTOM: kern[2]      <= cfg_data;
        cdcf_pkg::REG_DIVISOR:     divisor      <= cfg_data[cdcf_pkg::DIV_BITS-1:0];
        cdcf_pkg::REG_WIDTH:       image_width  <= cfg_data[cdcf_pkg::WID_REG_BITS-1:0];
        cdcf_pkg::REG_HEIGHT:      image_height <= cfg_data[HB-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry, saturated to the supported range
  always_comb begin
    iw_ext = WW'(image_width);
    if (iw_ext < WW'(cdcf_pkg::MIN_DIM)) begin
      w_eff = CW'(cdcf_pkg::MIN_DIM);
    end else if (iw_ext > WW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(iw_ext);
    end
    if (image_height < HB'(cdcf_pkg::MIN_DIM)) begin
      h_eff = HB'(cdcf_pkg::MIN_DIM);
    end else if (image_height > HB'(cdcf_pkg::MAX_HEIGHT)) begin
      h_eff = HB'(cdcf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  // position decode for the item in the read stage
  always_comb begin
    col_inc  = col_cnt + CW'(1);
    row_inc  = HB'(row_cnt) + HB'(1);
    interior = (row_cnt >= RB'(2)) && (col_cnt >= CW'(2)) &&
               (HB'(row_cnt) < h_eff) && (col_cnt < w_eff);
  end

  // line stores: older row in the upper half, newer row in the lower half
  cdcf_line_mem #(
    .DEPTH (MAX_WIDTH),
    .DW    (2 * PIXEL_BITS)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (mem_rd),
    .rd_addr (col_cnt[AW-1:0]),
    .rd_data (mem_q),
    .wr_en   (mem_wr),
    .wr_addr (col_cnt[AW-1:0]),
    .wr_data ({mem_q[PIXEL_BITS-1:0], px})
  );

  // capture the pixel on accept
  always_ff @(posedge clk) begin
    if (mem_rd) begin
      px <= pixel;
    end
  end

  // window shift, position counters and result position
  always_ff @(posedge clk) begin
    if (rst) begin
      win     <= '0;
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (mem_wr) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= mem_q[2*PIXEL_BITS-1:PIXEL_BITS];
      win[1][2] <= mem_q[PIXEL_BITS-1:0];
      win[2][2] <= px;
      if (col_inc >= w_eff) begin
        col_cnt <= '0;
        row_cnt <= (row_inc >= h_eff) ? '0 : row_inc[RB-1:0];
      end else begin
        col_cnt <= col_inc;
        if (HB'(row_cnt) >= h_eff) begin
          row_cnt <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mac_start) begin
      pos_row  <= row_cnt - RB'(1);
      pos_col  <= cdcf_pkg::COL_OUT_BITS'(col_cnt - CW'(1));
      pos_last <= (HB'(row_cnt) == h_eff - HB'(1)) && (col_cnt == w_eff - CW'(1));
    end
  end

  // multiply-accumulate over the nine taps
  cdcf_mac #(
    .PIXEL_BITS (PIXEL_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .start  (mac_start),
    .kern   (kern),
    .win    (win),
    .status (mac_st),
    .sum    (mac_sum)
  );

  // divide and clamp; a negative sum always clamps to zero
  always_comb begin
    sum_neg = mac_sum[SW-1];
    div_use = divisor > cdcf_pkg::DIV_BITS'(1);
    if (sum_neg) begin
      sum_sat = '0;
    end else if (mac_sum[SW-2:0] > DVW'(cdcf_pkg::OUT_MAX)) begin
      sum_sat = cdcf_pkg::OUT_MAX;
    end else begin
      sum_sat = mac_sum[OB-1:0];
    end
    quo_sat = (quot > DVW'(cdcf_pkg::OUT_MAX)) ? cdcf_pkg::OUT_MAX : quot[OB-1:0];
  end

  cdcf_div #(
    .NW (DVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mac_sum[SW-2:0]),
    .divisor  (divisor),
    .status   (div_st),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (state == cdcf_pkg::S_MAC && mac_st.done) begin
      res <= sum_sat;
    end else if (state == cdcf_pkg::S_DIV && div_st.done) begin
      res <= quo_sat;
    end
  end

  // sequencer state
  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdcf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cdcf_pkg::S_IDLE: begin
        if (in_valid) state_next = cdcf_pkg::S_READ;
      end
      cdcf_pkg::S_READ: begin
        state_next = interior ? cdcf_pkg::S_MAC : cdcf_pkg::S_IDLE;
      end
      cdcf_pkg::S_MAC: begin
        if (mac_st.done) begin
          state_next = (!sum_neg && div_use) ? cdcf_pkg::S_DIV : cdcf_pkg::S_PUSH;
        end
      end
      cdcf_pkg::S_DIV: begin
        if (div_st.done) state_next = cdcf_pkg::S_PUSH;
      end
      cdcf_pkg::S_PUSH: begin
        if (slot_free) state_next = cdcf_pkg::S_IDLE;
      end
      default: state_next = cdcf_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = (state != cdcf_pkg::S_IDLE);
    mem_rd    = (state == cdcf_pkg::S_IDLE) && in_valid;
    mem_wr    = (state == cdcf_pkg::S_READ);
    mac_start = (state == cdcf_pkg::S_READ) && interior;
    div_start = (state == cdcf_pkg::S_MAC) && mac_st.done && !sum_neg && div_use;
    out_load  = (state == cdcf_pkg::S_PUSH) && slot_free;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered_pixel <= res;
      out_row        <= pos_row;
      out_col        <= pos_col;
      last_of_plane  <= pos_last;
    end
  end

  // line store is never read and written in the same cycle
  a_mem_port: assert property (@(posedge clk) disable iff (rst) !(mem_rd && mem_wr))
    else $error("line store read and write overlap");

  // multiplier and divider never run together
  a_unit_excl: assert property (@(posedge clk) disable iff (rst)
      !(mac_st.busy && div_st.busy))
    else $error("mac and divider busy together");

  // an accepted item always goes to the memory read stage
  a_accept_read: assert property (@(posedge clk) disable iff (rst)
      (in_valid && !in_stall) |=> (state == cdcf_pkg::S_READ))
    else $error("accepted item skipped the read stage");

  // the end of plane mark sits on the last interior position
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
      (out_valid && last_of_plane) |->
      (out_row == RB'(h_eff - HB'(2))) &&
      (out_col == cdcf_pkg::COL_OUT_BITS'(w_eff - CW'(2))))
    else $error("last_of_plane on a wrong position");

endmodule

### dv/conv_filter_checker.sv
`timescale 1ns / 1ps
module conv_filter_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [PIXEL_BITS-1:0]             pixel,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [cdcf_pkg::OUT_BITS-1:0]     filtered_pixel,
  input  logic [cdcf_pkg::ROW_BITS-1:0]     out_row,
  input  logic [cdcf_pkg::COL_OUT_BITS-1:0] out_col,
  input  logic                              last_of_plane,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [cdcf_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [cdcf_pkg::KERN_BITS-1:0]    cfg_data,
  output int                                mismatch_cnt,
  output int                                results_due
);
  import cdcf_pkg::*;

  typedef struct packed {
    logic [OUT_BITS-1:0]     value;
    logic [ROW_BITS-1:0]     row;
    logic [COL_OUT_BITS-1:0] col;
    logic                    last;
  } filt_item_t;

  // expected filtered items, oldest first
  filt_item_t filt_expected[$];

  // shadow registers
  logic [KERN_BITS-1:0]    kern_rows [3];
  logic [DIV_BITS-1:0]     div_reg;
  logic [WID_REG_BITS-1:0] width_reg;
  logic [HGT_BITS-1:0]     height_reg;

  // shadow line stores, window and raster position
  logic [PIXEL_BITS-1:0] older_line [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] newer_line [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] win [3][3];
  int row_pos;
  int col_pos;

  int fail_cnt = 0;
  int due_cnt  = 0;
  int out_seen = 0;

  assign mismatch_cnt = fail_cnt;
  assign results_due  = due_cnt;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_cnt++;
  endtask

  always @(posedge clk) begin : predict_and_compare
    filt_item_t want;
    filt_item_t next_item;
    longint acc;
    int w_eff;
    int h_eff;
    int ci;
    int i;
    int j;
    if (rst) begin
      // register defaults: identity kernel, no division, 1024 x 768
      kern_rows[0] = '0;
      kern_rows[1] = KERN_MID_RST;
      kern_rows[2] = '0;
      div_reg      = DIV_RST;
      width_reg    = WIDTH_RST;
      height_reg   = HEIGHT_RST;
      for (i = 0; i < MAX_WIDTH; i++) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      for (i = 0; i < 3; i++)
        for (j = 0; j < 3; j++)
          win[i][j] = '0;
      row_pos = 0;
      col_pos = 0;
      filt_expected.delete();
    end else begin
      // compare an accepted result before anything new is queued
      if (out_valid && !out_stall) begin
        out_seen++;
        if (filt_expected.size() == 0) begin
          report_mismatch($sformatf("result %0d (row %0d col %0d) with none outstanding",
                                    out_seen, out_row, out_col));
        end else begin
          want = filt_expected.pop_front();
          if (filtered_pixel !== want.value)
            report_mismatch($sformatf("result %0d filtered_pixel %0d, expected %0d",
                                      out_seen, filtered_pixel, want.value));
          if (out_row !== want.row)
            report_mismatch($sformatf("result %0d out_row %0d, expected %0d",
                                      out_seen, out_row, want.row));
          if (out_col !== want.col)
            report_mismatch($sformatf("result %0d out_col %0d, expected %0d",
                                      out_seen, out_col, want.col));
          if (last_of_plane !== want.last)
            report_mismatch($sformatf("result %0d last_of_plane %0b, expected %0b",
                                      out_seen, last_of_plane, want.last));
        end
      end

      // register writes, spare indexes are ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KERN_TOP:    kern_rows[0] = cfg_data;
          REG_KERN_MIDDLE: kern_rows[1] = cfg_data;
          REG_KERN_BOTTOM: kern_rows[2] = cfg_data;
          REG_DIVISOR:     div_reg      = cfg_data[DIV_BITS-1:0];
          REG_WIDTH:       width_reg    = cfg_data[WID_REG_BITS-1:0];
          REG_HEIGHT:      height_reg   = cfg_data[HGT_BITS-1:0];
          default: ;
        endcase
      end

      // accepted pixel: shift the window, update line stores, maybe emit
      if (in_valid && !in_stall) begin
        w_eff = (width_reg < MIN_DIM) ? MIN_DIM :
                (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        h_eff = (height_reg < MIN_DIM) ? MIN_DIM :
                (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
        ci = col_pos % MAX_WIDTH;
        for (i = 0; i < 3; i++) begin
          win[i][0] = win[i][1];
          win[i][1] = win[i][2];
        end
        win[0][2] = older_line[ci];
        win[1][2] = newer_line[ci];
        win[2][2] = pixel;
        older_line[ci] = win[1][2];
        newer_line[ci] = pixel;

        if (row_pos >= 2 && col_pos >= 2 && row_pos < h_eff && col_pos < w_eff) begin
          acc = 0;
          for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
              acc += longint'(win[i][j]) *
                     longint'($signed(kern_rows[i][FIELD_BITS*j +: FIELD_BITS]));
          // signed division truncates toward zero
          if (div_reg > 1)
            acc = acc / longint'(div_reg);
          if (acc > longint'(OUT_MAX))
            acc = longint'(OUT_MAX);
          if (acc < 0)
            acc = 0;
          next_item.value = acc[OUT_BITS-1:0];
          next_item.row   = ROW_BITS'(row_pos - 1);
          next_item.col   = COL_OUT_BITS'(col_pos - 1);
          next_item.last  = (row_pos == h_eff - 1) && (col_pos == w_eff - 1);
          filt_expected.push_back(next_item);
        end

        // raster advance, counters beyond a shrunk bound wrap as at the bound
        col_pos++;
        if (col_pos >= w_eff) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= h_eff)
            row_pos = 0;
        end else if (row_pos >= h_eff) begin
          row_pos = 0;
        end
      end
    end
    due_cnt = filt_expected.size();
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import cdcf_pkg::*;

  localparam int     MAX_WIDTH    = 1024;
  localparam int     PIXEL_BITS   = 8;
  localparam int     DRAIN_CYCLES = 60;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     PHASE_ITEMS  = 420;
  localparam int     WIDE_COLS    = 40;
  localparam longint TIMEOUT_NS   = 64'd10_000_000;

  // indexes past the last register, writes there change nothing
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {
    PIX_RANDOM,
    PIX_SATURATED,
    PIX_CHECKER
  } pix_mode_e;

  typedef struct {
    logic [CFG_IDX_BITS-1:0] idx;
    logic [KERN_BITS-1:0]    data;
  } reg_write_t;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic [PIXEL_BITS-1:0]   pixel     = '0;
  logic                    out_stall = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [KERN_BITS-1:0]    cfg_data  = '0;

  logic                    in_stall;
  logic                    out_valid;
  logic [OUT_BITS-1:0]     filtered_pixel;
  logic [ROW_BITS-1:0]     out_row;
  logic [COL_OUT_BITS-1:0] out_col;
  logic                    last_of_plane;
  logic                    cfg_ready;

  int mismatch_cnt;
  int results_due;

  int   idle_pct    = 0;
  int   stall_pct   = 0;
  logic hold_req    = 1'b0;
  logic hold_taken  = 1'b0;
  int   hold_left   = 0;
  int   plane_items = 0;

  reg_write_t reg_writes[$];

  always #1 clk = ~clk;

  conv3x3_divide_clamp_filter #(
    .MAX_WIDTH  (MAX_WIDTH),
    .COEF_BITS  (FIELD_BITS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pixel          (pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_pixel (filtered_pixel),
    .out_row        (out_row),
    .out_col        (out_col),
    .last_of_plane  (last_of_plane),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  conv_filter_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pixel          (pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_pixel (filtered_pixel),
    .out_row        (out_row),
    .out_col        (out_col),
    .last_of_plane  (last_of_plane),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_cnt   (mismatch_cnt),
    .results_due    (results_due)
  );

  // result side: random stall, plus one long hold-off when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic queue_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [KERN_BITS-1:0] data);
    reg_write_t wr;
    wr.idx  = idx;
    wr.data = data;
    reg_writes.push_back(wr);
  endtask

  // register value in the low bits, random junk above it
  function automatic logic [KERN_BITS-1:0] with_junk(input logic [KERN_BITS-1:0] val,
                                                     input int bits);
    logic [KERN_BITS-1:0] junk;
    logic [KERN_BITS-1:0] low_mask;
    junk     = KERN_BITS'({$urandom, $urandom});
    low_mask = (KERN_BITS'(1) << bits) - KERN_BITS'(1);
    return (junk & ~low_mask) | (val & low_mask);
  endfunction

  // mostly small signed taps so results are not always clamped
  function automatic logic [KERN_BITS-1:0] random_kernel_row();
    logic [KERN_BITS-1:0] row;
    int k;
    row = KERN_BITS'({$urandom, $urandom});
    if ($urandom_range(4) != 0)
      for (k = 0; k < 3; k++)
        row[FIELD_BITS*k +: FIELD_BITS] = FIELD_BITS'($urandom_range(16) - 8);
    return row;
  endfunction

  task automatic flush_writes();
    reg_write_t wr;
    while (reg_writes.size() > 0) begin
      wr = reg_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= wr.idx;
      cfg_data  <= wr.data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [PIXEL_BITS-1:0] px);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // one whole plane, then wait until the block has gone quiet
  task automatic feed_plane(input int n_pix, input pix_mode_e mode);
    logic [PIXEL_BITS-1:0] px;
    int k;
    for (k = 0; k < n_pix; k++) begin
      case (mode)
        PIX_SATURATED: px = '1;
        PIX_CHECKER:   px = k[0] ? '0 : '1;
        default: begin
          if ($urandom_range(9) == 0)
            px = $urandom_range(1) ? '1 : '0;
          else
            px = PIXEL_BITS'($urandom);
        end
      endcase
      send_pixel(px);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    wait (results_due == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    plane_items += n_pix;
  endtask

  // new geometry and a random subset of the other registers, then one plane
  task automatic random_plane();
    int w_reg;
    int h_reg;
    int w_eff;
    int h_eff;
    logic [DIV_BITS-1:0] div_val;
    case ($urandom_range(19))
      0:       w_reg = $urandom_range(2);
      1, 2:    w_reg = $urandom_range(40, 11);
      default: w_reg = $urandom_range(10, 3);
    endcase
    h_reg = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(7, 3);
    w_eff = (w_reg < MIN_DIM) ? MIN_DIM : w_reg;
    h_eff = (h_reg < MIN_DIM) ? MIN_DIM : h_reg;
    case ($urandom_range(9))
      0:       div_val = '0;
      1:       div_val = DIV_BITS'(1);
      2:       div_val = '1;
      3:       div_val = DIV_BITS'($urandom);
      default: div_val = DIV_BITS'($urandom_range(20, 2));
    endcase
    if ($urandom_range(3) != 0) queue_write(REG_KERN_TOP, random_kernel_row());
    if ($urandom_range(3) != 0) queue_write(REG_KERN_MIDDLE, random_kernel_row());
    if ($urandom_range(3) != 0) queue_write(REG_KERN_BOTTOM, random_kernel_row());
    if ($urandom_range(1) != 0)
      queue_write(REG_DIVISOR, with_junk(KERN_BITS'(div_val), DIV_BITS));
    if ($urandom_range(19) == 0)
      queue_write($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                  KERN_BITS'({$urandom, $urandom}));
    queue_write(REG_WIDTH, with_junk(KERN_BITS'(w_reg), WID_REG_BITS));
    queue_write(REG_HEIGHT, with_junk(KERN_BITS'(h_reg), HGT_BITS));
    flush_writes();
    feed_plane(w_eff * h_eff, PIX_RANDOM);
  endtask

  task automatic run_phase(input int send_idle, input int recv_stall);
    idle_pct    = send_idle;
    stall_pct   = recv_stall;
    plane_items = 0;
    while (plane_items < PHASE_ITEMS)
      random_plane();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset kernel and divisor on the smallest plane
    queue_write(REG_WIDTH, with_junk(KERN_BITS'(MIN_DIM), WID_REG_BITS));
    queue_write(REG_HEIGHT, with_junk(KERN_BITS'(MIN_DIM), HGT_BITS));
    flush_writes();
    feed_plane(9, PIX_RANDOM);

    // largest positive taps, divisor zero, full-scale pixels: clamp high
    queue_write(REG_KERN_TOP, {3{16'h7FFF}});
    queue_write(REG_KERN_MIDDLE, {3{16'h7FFF}});
    queue_write(REG_KERN_BOTTOM, {3{16'h7FFF}});
    queue_write(REG_DIVISOR, with_junk('0, DIV_BITS));
    queue_write(REG_SPARE_LO, '1);
    flush_writes();
    feed_plane(9, PIX_SATURATED);

    // most negative taps, largest divisor, geometry below range: clamp low
    queue_write(REG_KERN_TOP, {3{16'h8000}});
    queue_write(REG_KERN_MIDDLE, {3{16'h8000}});
    queue_write(REG_KERN_BOTTOM, {3{16'h8000}});
    queue_write(REG_DIVISOR, with_junk('1, DIV_BITS));
    queue_write(REG_WIDTH, with_junk('0, WID_REG_BITS));
    queue_write(REG_HEIGHT, with_junk(KERN_BITS'(2), HGT_BITS));
    queue_write(REG_SPARE_HI, KERN_BITS'({$urandom, $urandom}));
    flush_writes();
    feed_plane(9, PIX_CHECKER);

    // no idling, with one long hold-off on the result side
    hold_req <= 1'b1;
    run_phase(0, 0);

    // wider rows, height below range saturates
    queue_write(REG_KERN_MIDDLE, random_kernel_row());
    queue_write(REG_DIVISOR, with_junk(KERN_BITS'(1), DIV_BITS));
    queue_write(REG_WIDTH, with_junk(KERN_BITS'(WIDE_COLS), WID_REG_BITS));
    queue_write(REG_HEIGHT, with_junk('0, HGT_BITS));
    flush_writes();
    feed_plane(WIDE_COLS * MIN_DIM, PIX_RANDOM);

    run_phase(58, 0);
    run_phase(0, 58);
    run_phase(22, 22);

    if (mismatch_cnt == 0)
      $display("conv3x3_divide_clamp_filter: match");
    else
      $display("conv3x3_divide_clamp_filter: mismatch");
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("conv3x3_divide_clamp_filter: mismatch");
    $finish;
  end

endmodule
